/* sv/sacl_pkg.sv */
// Shared types and constants of the set-associative LRU byte cache.
package sacl_pkg;
    localparam int LINES      = 8;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_BITS  = 13;
    localparam int SLOT_BITS  = $clog2(LINES);
    localparam int OFF_BITS   = $clog2(LINE_BYTES);
    localparam int BLK_BITS   = ADDR_BITS - OFF_BITS;
    localparam int MEM_BITS   = SLOT_BITS + OFF_BITS;
    localparam int WL_BITS    = 2;

    localparam logic [2:0]  RANK_MAX = 3'd7;
    localparam logic [15:0] HIT_MAX  = 16'hFFFF;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_FILL    = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_STRAY   = 3'd4;
    localparam logic [2:0] ST_REFUSED = 3'd5;

    localparam logic OP_READ = 1'b0;
    localparam logic OP_FILL = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [12:0] address;
        logic [7:0]  fill_data;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_data;
        logic [7:0]  fetch_block;
        logic [15:0] hit_count;
    } t_out;

    typedef struct packed {
        logic                is_fill;
        logic [BLK_BITS-1:0] block;
        logic [OFF_BITS-1:0] offset;
        logic [7:0]          fill_data;
    } t_cmd;
endpackage

/* sv/sacl_front.sv */
// Front queue: accepts beats and splits each beat's address into block and offset.
module sacl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sacl_pkg::t_in i_in,
    output logic          o_cmd_valid,
    output sacl_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);
    import sacl_pkg::*;

    t_cmd       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;
    t_cmd       w_cmd;

    assign full        = (r_cnt == 3'd4);
    assign o_cmd_valid = (r_cnt != 3'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_take && o_cmd_valid;

    always_comb begin
        w_cmd.is_fill   = (i_in.operation == OP_FILL);
        w_cmd.block     = i_in.address[ADDR_BITS-1:OFF_BITS];
        w_cmd.offset    = i_in.address[OFF_BITS-1:0];
        w_cmd.fill_data = i_in.fill_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, w_push} - {2'b0, w_pop};
        end
    end
endmodule

/* sv/sacl_outq.sv */
// Result queue between the lookup pipeline and the result port.
module sacl_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  sacl_pkg::t_out i_res,
    output logic [2:0]     o_cnt,
    output logic           empty,
    input  logic           pop,
    output sacl_pkg::t_out o_out
);
    import sacl_pkg::*;

    t_out       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;

    assign o_cnt = r_cnt;
    assign empty = (r_cnt == 3'd0);
    assign o_out = r_q[r_rp];
    assign w_pop = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_res;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, i_wr} - {2'b0, w_pop};
        end
    end
endmodule

/* sv/sacl_back.sv */
// Back end: tag lookup, LRU, miss tracking, line byte memory and result stage.
module sacl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_data,
    input  logic           i_cmd_valid,
    input  sacl_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    input  logic [2:0]     i_out_cnt,
    output logic           o_res_wr,
    output sacl_pkg::t_out o_res
);
    import sacl_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic        use_mem;
        logic [7:0]  data;
        logic [7:0]  fetch;
        logic [15:0] hit;
    } t_s2;

    logic [WL_BITS-1:0]   r_wl;
    logic [LINES-1:0]     r_valid, n_valid;
    logic [BLK_BITS-1:0]  r_block [LINES];
    logic [BLK_BITS-1:0]  n_block [LINES];
    logic [2:0]           r_rank [LINES];
    logic [2:0]           n_rank [LINES];
    logic                 r_miss_pending, n_miss_pending;
    logic [SLOT_BITS-1:0] r_miss_slot, n_miss_slot;
    logic [OFF_BITS-1:0]  r_miss_off, n_miss_off;
    logic [OFF_BITS-1:0]  r_fill_cnt, n_fill_cnt;
    logic [7:0]           r_req_byte, n_req_byte;
    logic [15:0]          r_hit, n_hit;
    logic [7:0]           r_mem [LINES*LINE_BYTES];
    logic [7:0]           r_rdata;
    logic                 r_s2_valid;
    t_s2                  r_s2, n_s2;

    logic                 w_issue;
    logic [SLOT_BITS-1:0] w_base, w_ref, w_slot, w_set_mask, w_way_mask;
    logic [LINES-1:0]     w_in_set;
    logic                 w_hit, w_found_inv, w_have, w_touch, w_was_valid;
    logic [SLOT_BITS-1:0] w_hit_slot, w_inv_slot, w_lru_slot;
    logic [2:0]           w_best;
    logic                 w_mem_we;
    logic [MEM_BITS-1:0]  w_waddr, w_raddr;

    assign w_issue    = i_cmd_valid && ((i_out_cnt + {2'b0, r_s2_valid}) < 3'd4);
    assign o_cmd_take = w_issue;

    always_comb begin
        w_way_mask = SLOT_BITS'((1 << r_wl) - 1);
        w_set_mask = ~w_way_mask;
        // set index is block mod sets, scaled by the way count
        w_base     = (i_cmd.block[SLOT_BITS-1:0] << r_wl) & w_set_mask;
        w_ref      = i_cmd.is_fill ? r_miss_slot : w_base;
        for (int v = 0; v < LINES; v++) begin
            w_in_set[v] = ((SLOT_BITS'(v) ^ w_ref) & w_set_mask) == '0;
        end
        w_hit      = 1'b0;
        w_hit_slot = '0;
        w_found_inv = 1'b0;
        w_inv_slot = '0;
        for (int v = LINES - 1; v >= 0; v--) begin
            if (w_in_set[v] && r_valid[v] && r_block[v] == i_cmd.block) begin
                w_hit      = 1'b1;
                w_hit_slot = SLOT_BITS'(v);
            end
            if (w_in_set[v] && !r_valid[v]) begin
                w_found_inv = 1'b1;
                w_inv_slot  = SLOT_BITS'(v);
            end
        end
        w_have     = 1'b0;
        w_best     = '0;
        w_lru_slot = '0;
        for (int v = 0; v < LINES; v++) begin
            if (w_in_set[v] && (!w_have || r_rank[v] > w_best)) begin
                w_have     = 1'b1;
                w_best     = r_rank[v];
                w_lru_slot = SLOT_BITS'(v);
            end
        end

        n_valid        = r_valid;
        n_block        = r_block;
        n_miss_pending = r_miss_pending;
        n_miss_slot    = r_miss_slot;
        n_miss_off     = r_miss_off;
        n_fill_cnt     = r_fill_cnt;
        n_req_byte     = r_req_byte;
        n_hit          = r_hit;
        w_touch        = 1'b0;
        w_was_valid    = 1'b1;
        w_slot         = w_hit_slot;
        w_mem_we       = 1'b0;
        w_waddr        = {r_miss_slot, r_fill_cnt};
        w_raddr        = {w_hit_slot, i_cmd.offset};
        n_s2           = '0;

        if (!i_cmd.is_fill) begin
            if (r_miss_pending) begin
                n_s2.status = ST_REFUSED;
            end else if (w_hit) begin
                w_touch = 1'b1;
                if (r_hit != HIT_MAX) begin
                    n_hit = r_hit + 16'd1;
                end
                n_s2.status  = ST_HIT;
                n_s2.use_mem = 1'b1;
            end else begin
                w_slot = w_found_inv ? w_inv_slot : w_lru_slot;
                n_valid[w_slot] = 1'b0;
                n_block[w_slot] = i_cmd.block;
                n_miss_pending  = 1'b1;
                n_miss_slot     = w_slot;
                n_miss_off      = i_cmd.offset;
                n_fill_cnt      = '0;
                n_s2.status     = ST_MISS;
                n_s2.fetch      = i_cmd.block[7:0];
            end
        end else begin
            if (!r_miss_pending) begin
                n_s2.status = ST_STRAY;
            end else begin
                w_mem_we = 1'b1;
                if (r_fill_cnt == r_miss_off) begin
                    n_req_byte = i_cmd.fill_data;
                end
                if (r_fill_cnt == OFF_BITS'(LINE_BYTES - 1)) begin
                    w_touch        = 1'b1;
                    w_was_valid    = 1'b0;
                    w_slot         = r_miss_slot;
                    n_valid[r_miss_slot] = 1'b1;
                    n_miss_pending = 1'b0;
                    n_fill_cnt     = '0;
                    n_s2.status    = ST_DONE;
                    n_s2.data      = (r_fill_cnt == r_miss_off) ? i_cmd.fill_data
                                                                : r_req_byte;
                end else begin
                    n_fill_cnt  = r_fill_cnt + OFF_BITS'(1);
                    n_s2.status = ST_FILL;
                end
            end
        end
        n_s2.hit = n_hit;

        n_rank = r_rank;
        if (w_touch) begin
            for (int v = 0; v < LINES; v++) begin
                if (w_in_set[v] && SLOT_BITS'(v) != w_slot && r_valid[v] &&
                    (!w_was_valid || r_rank[v] < r_rank[w_slot]) &&
                    r_rank[v] != RANK_MAX) begin
                    n_rank[v] = r_rank[v] + 3'd1;
                end
            end
            n_rank[w_slot] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue && w_mem_we) begin
            r_mem[w_waddr] <= i_cmd.fill_data;
        end
        r_rdata <= r_mem[w_raddr];
        if (w_issue) begin
            r_s2 <= n_s2;
        end
        if (!i_rst_n) begin
            r_wl           <= '0;
            r_valid        <= '0;
            r_block        <= '{default: '0};
            r_rank         <= '{default: '0};
            r_miss_pending <= 1'b0;
            r_miss_slot    <= '0;
            r_miss_off     <= '0;
            r_fill_cnt     <= '0;
            r_req_byte     <= '0;
            r_hit          <= '0;
            r_s2_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wl <= i_cfg_data;
            end
            r_s2_valid <= w_issue;
            if (w_issue) begin
                r_valid        <= n_valid;
                r_block        <= n_block;
                r_rank         <= n_rank;
                r_miss_pending <= n_miss_pending;
                r_miss_slot    <= n_miss_slot;
                r_miss_off     <= n_miss_off;
                r_fill_cnt     <= n_fill_cnt;
                r_req_byte     <= n_req_byte;
                r_hit          <= n_hit;
            end
        end
    end

    always_comb begin
        o_res_wr          = r_s2_valid;
        o_res.status      = r_s2.status;
        o_res.read_data   = r_s2.use_mem ? r_rdata : r_s2.data;
        o_res.fetch_block = r_s2.fetch;
        o_res.hit_count   = r_s2.hit;
    end

    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_miss_pending |-> r_fill_cnt == '0) else $error("fill count without miss");
    a_slot_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss_pending |-> !r_valid[r_miss_slot]) else $error("pending slot valid");
    a_issue_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> r_s2_valid) else $error("issued beat lost");
    a_hit_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit != $past(r_hit) |-> r_hit == $past(r_hit) + 16'd1)
        else $error("hit count jump");
endmodule

/* sv/set_associative_cache_lru_unit.sv */
// Top level of the set-associative read-only byte cache with true LRU.
// A beat is accepted whenever the 4-entry input queue is not full; the lookup
// stage retires one beat per cycle (tag compare over up to 8 ways, LRU update
// and one port of the 256-byte line memory), and the result is registered
// before a 4-entry result queue. The lookup stage stalls only while the
// result queue and its result register are full. No clearing pass after reset.
module set_associative_cache_lru_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  sacl_pkg::t_in  i_in,
    output logic           empty,
    input  logic           pop,
    output sacl_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_data
);
    import sacl_pkg::*;

    logic       w_cmd_valid, w_cmd_take, w_res_wr;
    t_cmd       w_cmd;
    t_out       w_res;
    logic [2:0] w_out_cnt;

    sacl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_in),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    sacl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .i_out_cnt(w_out_cnt), .o_res_wr(w_res_wr), .o_res(w_res)
    );

    sacl_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_res_wr), .i_res(w_res),
        .o_cnt(w_out_cnt), .empty(empty), .pop(pop), .o_out(o_out)
    );
endmodule
